[rtl/gamepad_report_deadzone_mapper_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the gamepad report deadzone mapper
// Shared immediate-style wrappers around concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_DEADZONE_MAPPER_MACROS_SVH
`define GAMEPAD_REPORT_DEADZONE_MAPPER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GDM_ASSERT_NOW(label, clk, rst_n, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define GDM_ASSERT_NEXT(label, clk, rst_n, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gdm_pkg.sv]
// ---------------------------------------------------------------------------
// gdm_pkg
// Types and constants shared by the deadzone mapper pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdm_pkg;

    // Lane layout: four stick axes, then two triggers
    localparam int AXES  = 4;
    localparam int TRIGS = 2;
    localparam int LANES = AXES + TRIGS;

    // Divider widths: numerator, divisor, reciprocal, fraction bits
    localparam int NUM_W = 16;
    localparam int DEN_W = 8;
    localparam int RCP_W = 17;
    localparam int FRAC  = 16;
    localparam int PRD_W = NUM_W + RCP_W;

    // Report field widths
    localparam int BTN_W  = 13;
    localparam int HAT_W  = 4;
    localparam int DATA_W = 72;

    localparam logic [HAT_W-1:0] HAT_NEUTRAL = 4'd8;
    localparam logic [15:0]      BUTTON_MASK = 16'h1FFF;

    // Configuration register indexes
    localparam logic CFG_STICK_DZ = 1'b0;
    localparam logic CFG_TRIG_DZ  = 1'b1;

    localparam logic [6:0] STICK_DZ_RESET = 7'd8;
    localparam logic [7:0] TRIG_DZ_RESET  = 8'd0;

    // Per-stage advance enables
    typedef struct packed {
        logic st5;
        logic st4;
        logic st3;
        logic st2;
        logic st1;
    } gdm_adv_t;

    // Side payload that rides along the divider stages
    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [HAT_W-1:0] hat;
        logic [AXES-1:0]  neg;
    } gdm_side_t;

endpackage

[rtl/gdm_prep.sv]
// ---------------------------------------------------------------------------
// gdm_prep
// Stage 1: deadzone tests and divider operand setup for every lane.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdm_prep (
    input  logic                                            clk,
    input  gdm_pkg::gdm_adv_t                               adv,
    input  logic [6:0]                                      stick_dz,
    input  logic [7:0]                                      trig_dz,
    input  logic [gdm_pkg::AXES-1:0][7:0]                   axis_raw,
    input  logic [gdm_pkg::TRIGS-1:0][7:0]                  trig_raw,
    output logic [gdm_pkg::LANES-1:0][gdm_pkg::NUM_W-1:0]   num_reg,
    output logic [gdm_pkg::LANES-1:0][gdm_pkg::DEN_W-1:0]   den_reg,
    output logic [gdm_pkg::LANES-1:0][gdm_pkg::RCP_W-1:0]   recip_reg
);
    import gdm_pkg::*;

    localparam int LUT_N = 1 << DEN_W;

    logic [RCP_W-1:0]                 recip_lut [LUT_N];
    logic [LANES-1:0][NUM_W-1:0]      num_next;
    logic [LANES-1:0][DEN_W-1:0]      den_next;
    logic [LANES-1:0][RCP_W-1:0]      recip_next;
    logic [AXES-1:0][7:0]             mag;
    logic [AXES-1:0][7:0]             adj;
    logic [TRIGS-1:0][7:0]            diff;
    logic                             stick_scale;
    logic                             trig_scale;

    // Reciprocal table: floor(2^FRAC / a), entry zero unused
    for (genvar i = 0; i < LUT_N; i++) begin : g_rcp
        if (i == 0) begin : g_zero
            assign recip_lut[i] = '0;
        end
        else begin : g_val
            localparam int unsigned RV = (1 << FRAC) / i;
            assign recip_lut[i] = RV[RCP_W-1:0];
        end
    end

    assign stick_scale = (stick_dz != 7'd0) && (stick_dz != 7'd127);
    assign trig_scale  = (trig_dz != 8'd0) && (trig_dz != 8'd255);

    // Build numerator and divisor; snap and pass-through use a divisor of one
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            mag[i] = axis_raw[i][7] ? {1'b0, axis_raw[i][6:0]} : 8'd128 - axis_raw[i];
            adj[i] = mag[i] - {1'b0, stick_dz};
            if (mag[i] < {1'b0, stick_dz})
            begin
                num_next[i] = '0;
                den_next[i] = 8'd1;
            end
            else if (stick_scale)
            begin
                num_next[i] = {1'b0, adj[i], 7'd0} - {8'd0, adj[i]};
                den_next[i] = 8'd127 - {1'b0, stick_dz};
            end
            else
            begin
                num_next[i] = {8'd0, mag[i]};
                den_next[i] = 8'd1;
            end
        end
        for (int t = 0; t < TRIGS; t++)
        begin
            diff[t] = trig_raw[t] - trig_dz;
            if (trig_raw[t] < trig_dz)
            begin
                num_next[AXES+t] = '0;
                den_next[AXES+t] = 8'd1;
            end
            else if (trig_scale)
            begin
                num_next[AXES+t] = {diff[t], 8'd0} - {8'd0, diff[t]};
                den_next[AXES+t] = ~trig_dz;
            end
            else
            begin
                num_next[AXES+t] = {8'd0, trig_raw[t]};
                den_next[AXES+t] = 8'd1;
            end
        end
        for (int k = 0; k < LANES; k++)
        begin
            recip_next[k] = recip_lut[den_next[k]];
        end
    end

    // Load stage 1
    always_ff @(posedge clk)
    begin
        if (adv.st1)
        begin
            num_reg   <= num_next;
            den_reg   <= den_next;
            recip_reg <= recip_next;
        end
    end

endmodule

[rtl/gdm_div.sv]
// ---------------------------------------------------------------------------
// gdm_div
// Stages 2-4: reciprocal multiply, back-multiply, one-step quotient fixup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdm_div (
    input  logic                        clk,
    input  gdm_pkg::gdm_adv_t           adv,
    input  logic [gdm_pkg::NUM_W-1:0]   num,
    input  logic [gdm_pkg::DEN_W-1:0]   den,
    input  logic [gdm_pkg::RCP_W-1:0]   recip,
    output logic [gdm_pkg::NUM_W-1:0]   quo_reg
);
    import gdm_pkg::*;

    localparam int BK_W = NUM_W + DEN_W;

    logic [PRD_W-1:0] p_reg;
    logic [NUM_W-1:0] n2_reg;
    logic [DEN_W-1:0] a2_reg;
    logic [NUM_W-1:0] qe_reg;
    logic [BK_W-1:0]  bk_reg;
    logic [NUM_W-1:0] n3_reg;
    logic [DEN_W-1:0] a3_reg;
    logic [NUM_W-1:0] qe_next;
    logic [NUM_W-1:0] rem;

    // Estimate is floor or one below; the slice drops the fraction
    assign qe_next = p_reg[FRAC+NUM_W-1:FRAC];
    assign rem     = n3_reg - bk_reg[NUM_W-1:0];

    always_ff @(posedge clk)
    begin
        // Multiply by reciprocal
        if (adv.st2)
        begin
            p_reg  <= PRD_W'(num) * PRD_W'(recip);
            n2_reg <= num;
            a2_reg <= den;
        end
        // Multiply estimate back by divisor
        if (adv.st3)
        begin
            qe_reg <= qe_next;
            bk_reg <= BK_W'(qe_next) * BK_W'(a2_reg);
            n3_reg <= n2_reg;
            a3_reg <= a2_reg;
        end
        // Bump estimate when remainder still covers the divisor
        if (adv.st4)
        begin
            quo_reg <= (rem >= NUM_W'(a3_reg)) ? qe_reg + 1'b1 : qe_reg;
        end
    end

endmodule

[rtl/gamepad_report_deadzone_mapper.sv]
// ---------------------------------------------------------------------------
// gamepad_report_deadzone_mapper
// Conditions one raw gamepad report into one cleaned report per word.
// ---------------------------------------------------------------------------
// Usage:
//   Raw reports enter on the s_axis stream, cleaned reports leave on m_axis,
//   one output word per input word, in order. Deadzones are set through the
//   cfg write port (index 0 stick deadzone, index 1 trigger deadzone); write
//   them only while no word is in flight.
//   Pipeline: five register stages (prep, three divider stages, output
//   register); the prep stage loads at the accepting edge. Throughput: one
//   word per cycle while m_axis_tready is high; the six per-lane divider
//   pipelines form the three divider stages.
//   Each stage has its own valid bit and loads when it is empty or the stage
//   after it loads, so bubbles collapse and s_axis_tready stays high while
//   the output word waits, until every stage is full.
//   Reset clears all valid bits and sets the stick deadzone to 8 and the
//   trigger deadzone to 0. A stalled receiver holds the output word stable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gamepad_report_deadzone_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_buttons[15:0], left_stick_x, left_stick_y, right_stick_x,
    // right_stick_y, left_trigger_raw, right_trigger_raw, dpad_code (8 each)
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // buttons_out[12:0], left_x_out, left_y_out, right_x_out, right_y_out,
    // left_trigger_out, right_trigger_out (8 each), hat_out (4), zero pad (7)
    output logic [71:0] m_axis_tdata
);
    import gdm_pkg::*;

`include "gamepad_report_deadzone_mapper_macros.svh"

    logic [6:0]                   stick_dz_reg;
    logic [7:0]                   trig_dz_reg;
    logic [5:1]                   v_reg;
    logic [5:1]                   rdy;
    gdm_adv_t                     adv;
    gdm_side_t                    side_in;
    gdm_side_t                    side1_reg;
    gdm_side_t                    side2_reg;
    gdm_side_t                    side3_reg;
    gdm_side_t                    side4_reg;
    logic [AXES-1:0][7:0]         axis_raw;
    logic [TRIGS-1:0][7:0]        trig_raw;
    logic [LANES-1:0][NUM_W-1:0]  num1;
    logic [LANES-1:0][DEN_W-1:0]  den1;
    logic [LANES-1:0][RCP_W-1:0]  recip1;
    logic [LANES-1:0][NUM_W-1:0]  quo4;
    logic [AXES-1:0][7:0]         axis_out;
    logic [TRIGS-1:0][7:0]        trig_out;
    logic [DATA_W-1:0]            out_next;
    logic [DATA_W-1:0]            out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_dz_reg <= STICK_DZ_RESET;
            trig_dz_reg  <= TRIG_DZ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_STICK_DZ: stick_dz_reg <= cfg_wdata[6:0];
                CFG_TRIG_DZ:  trig_dz_reg  <= cfg_wdata;
            endcase
        end
    end

    // Ready ripples back from the output register
    always_comb
    begin
        rdy[5] = !v_reg[5] || m_axis_tready;
        for (int k = 4; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign adv           = '{st5: rdy[5], st4: rdy[4], st3: rdy[3], st2: rdy[2], st1: rdy[1]};
    assign s_axis_tready = rdy[1];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= 5; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Unpack input word
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            axis_raw[i] = s_axis_tdata[16 + 8*i +: 8];
        end
        for (int t = 0; t < TRIGS; t++)
        begin
            trig_raw[t] = s_axis_tdata[48 + 8*t +: 8];
        end
        side_in.buttons = s_axis_tdata[BTN_W-1:0];
        side_in.hat     = (s_axis_tdata[71:64] > 8'(HAT_NEUTRAL)) ? HAT_NEUTRAL
                                                                : s_axis_tdata[67:64];
        for (int i = 0; i < AXES; i++)
        begin
            side_in.neg[i] = !axis_raw[i][7];
        end
    end

    gdm_prep u_prep (
        .clk       (clk),
        .adv       (adv),
        .stick_dz  (stick_dz_reg),
        .trig_dz   (trig_dz_reg),
        .axis_raw  (axis_raw),
        .trig_raw  (trig_raw),
        .num_reg   (num1),
        .den_reg   (den1),
        .recip_reg (recip1)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        gdm_div u_div (
            .clk     (clk),
            .adv     (adv),
            .num     (num1[l]),
            .den     (den1[l]),
            .recip   (recip1[l]),
            .quo_reg (quo4[l])
        );
    end

    // Carry buttons, hat and axis signs alongside the dividers
    always_ff @(posedge clk)
    begin
        if (adv.st1)
        begin
            side1_reg <= side_in;
        end
        if (adv.st2)
        begin
            side2_reg <= side1_reg;
        end
        if (adv.st3)
        begin
            side3_reg <= side2_reg;
        end
        if (adv.st4)
        begin
            side4_reg <= side3_reg;
        end
    end

    // Recenter axes and clamp, saturate triggers
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (side4_reg.neg[i])
            begin
                axis_out[i] = (quo4[i] > NUM_W'(128)) ? 8'd0 : 8'd128 - quo4[i][7:0];
            end
            else
            begin
                axis_out[i] = (quo4[i] > NUM_W'(127)) ? 8'd255 : {1'b1, quo4[i][6:0]};
            end
        end
        for (int t = 0; t < TRIGS; t++)
        begin
            trig_out[t] = (quo4[AXES+t] > NUM_W'(255)) ? 8'd255 : quo4[AXES+t][7:0];
        end
        out_next = {7'd0, side4_reg.hat, trig_out[1], trig_out[0],
                    axis_out[3], axis_out[2], axis_out[1], axis_out[0], side4_reg.buttons};
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv.st5)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = v_reg[5];
    assign m_axis_tdata  = out_reg;

    `GDM_ASSERT_NEXT(a_stage1_hold, clk, rst_n, v_reg[1] && !rdy[2], v_reg[1],
        "stage 1 word dropped while stalled")

    `GDM_ASSERT_NOW(a_full_blocks, clk, rst_n, (&v_reg) && !m_axis_tready, !s_axis_tready,
        "input accepted with every stage full and output stalled")

    `GDM_ASSERT_NOW(a_hat_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[64:61] <= HAT_NEUTRAL,
        "hat output above neutral code")

endmodule
